>>> design/assert_macros.svh
// Assertion helpers for the page-write framer checkers.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define EPWF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the same edge.
`define EPWF_ASSERT_IMPL(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

>>> design/epwf_pkg.sv
`default_nettype none
package epwf_pkg;

    localparam int unsigned EPWF_QUEUE_DEPTH = 2;
    localparam logic [7:0]  EPWF_DEV_ADDR_RESET = 8'hA2;
    localparam logic [2:0]  EPWF_PAGE_LOG2_RESET = 3'd3;
    localparam logic [2:0]  EPWF_PAGE_LOG2_MAX = 3'd5;

    // Register indexes on the configuration port
    typedef enum logic {
        CFG_DEVICE_ADDRESS = 1'b0,
        CFG_PAGE_SIZE_LOG2 = 1'b1
    } cfg_index_t;

    // Bus action codes
    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_SEND  = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_POLL  = 2'd3
    } action_t;

    // Steps of the back-end sequencer, in emission order
    typedef enum logic [2:0] {
        STEP_PRE_STOP  = 3'd0,
        STEP_PRE_POLL  = 3'd1,
        STEP_START     = 3'd2,
        STEP_DEV       = 3'd3,
        STEP_ADDR      = 3'd4,
        STEP_DATA      = 3'd5,
        STEP_POST_STOP = 3'd6,
        STEP_POST_POLL = 3'd7
    } step_t;

    // One classified item as handed from front to back
    typedef struct packed {
        logic       pre_close;
        logic       open;
        logic [7:0] seg_addr;
        logic [7:0] data;
        logic       post_close;
    } cmd_t;

endpackage
`default_nettype wire

>>> design/eeprom_page_write_framer_top.sv
// EEPROM page-write framer.
// Input stream (s_*): one item per data byte of a write request. s_tuser marks the
// first byte, whose s_tdata[7:0] carries the start memory address; s_tlast marks the
// final byte. Output stream (m_*): one item per I2C bus action, m_tuser is the action
// (start, send byte, stop, standby poll), m_tdata the byte to send, m_tlast flags the
// last action caused by an input item.
// Configuration port (cfg_*): index 0 writes the device address byte, index 1 the
// page size as log2; write only while the block is idle. cfg_ready is always high.
// With the sequencer idle, an item taken at the input is written into a queue slot, and
// its first action is then registered in the output register that drives m_*.
// Each input item yields 1 to 8 actions, one per cycle while m_tready is high, over
// the single output register; the output channel sets the pace.
// A short queue between the classifier and the action sequencer lets the next bytes
// be taken while earlier actions drain.
// Reset clears the address and segment state and loads the register defaults
// (device address 0xA2, 8-byte pages); no bus action is pending after reset.
// When the receiver stalls, the current action holds and input is taken until the
// queue fills.
`default_nettype none
module eeprom_page_write_framer_top
    import epwf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = EPWF_QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] start_addr, [15:8] data_byte
    input  wire logic        s_tuser,   // [0] first
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] tx_value
    output logic [1:0]       m_tuser,   // [1:0] action
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic [7:0] dev_addr_reg;
    logic [2:0] page_log2_reg;
    logic       push;
    cmd_t       push_cmd;
    logic       queue_full;
    logic       head_valid;
    cmd_t       head_cmd;
    logic       pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg  <= EPWF_DEV_ADDR_RESET;
            page_log2_reg <= EPWF_PAGE_LOG2_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_DEVICE_ADDRESS: dev_addr_reg  <= cfg_data;
                CFG_PAGE_SIZE_LOG2: page_log2_reg <= cfg_data[2:0];
                default:            dev_addr_reg  <= dev_addr_reg;
            endcase
        end
    end

    epwf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .start_addr     (s_tdata[7:0]),
        .first          (s_tuser),
        .data_byte      (s_tdata[15:8]),
        .final_byte     (s_tlast),
        .page_size_log2 (page_log2_reg),
        .queue_full     (queue_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    epwf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    epwf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (head_valid),
        .cmd            (head_cmd),
        .cmd_pop        (pop),
        .device_address (dev_addr_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_value      (m_tdata),
        .out_action     (m_tuser),
        .out_last       (m_tlast)
    );

endmodule
`default_nettype wire

>>> design/epwf_front.sv
`default_nettype none
module epwf_front
    import epwf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] start_addr,
    input  wire logic       first,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    input  wire logic [2:0] page_size_log2,
    input  wire logic       queue_full,
    output logic            push,
    output cmd_t            push_cmd
);

    logic [7:0] next_addr_reg;
    logic [7:0] next_addr_next;
    logic       seg_open_reg;
    logic       seg_open_next;
    logic [2:0] lg;
    logic [7:0] mask;
    logic [7:0] base;
    logic [7:0] addr_inc;
    logic       boundary;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        lg       = (page_size_log2 > EPWF_PAGE_LOG2_MAX) ? EPWF_PAGE_LOG2_MAX : page_size_log2;
        mask     = (8'd1 << lg) - 8'd1;
        base     = first ? start_addr : next_addr_reg;
        addr_inc = base + 8'd1;
        boundary = ((addr_inc & mask) == 8'd0);

        push_cmd.pre_close  = first && seg_open_reg;
        push_cmd.open       = first || !seg_open_reg;
        push_cmd.seg_addr   = base;
        push_cmd.data       = data_byte;
        push_cmd.post_close = final_byte || boundary;

        next_addr_next = next_addr_reg;
        seg_open_next  = seg_open_reg;
        if (push)
        begin
            next_addr_next = addr_inc;
            seg_open_next  = !push_cmd.post_close;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_addr_reg <= 8'd0;
            seg_open_reg  <= 1'b0;
        end
        else
        begin
            next_addr_reg <= next_addr_next;
            seg_open_reg  <= seg_open_next;
        end
    end

endmodule
`default_nettype wire

>>> design/epwf_queue.sv
`default_nettype none
module epwf_queue
    import epwf_pkg::*;
#(
    parameter int unsigned DEPTH = EPWF_QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> design/epwf_back.sv
`default_nettype none
module epwf_back
    import epwf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    input  wire cmd_t       cmd,
    output logic            cmd_pop,
    input  wire logic [7:0] device_address,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_value,
    output logic [1:0]      out_action,
    output logic            out_last
);

    step_t      step_reg;
    step_t      step_next;
    logic       active_reg;
    logic       active_next;
    step_t      cur_step;
    step_t      succ_step;
    logic       cmd_done;
    logic       load;
    action_t    act;
    logic [7:0] val;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_value_reg;
    logic [1:0] out_action_reg;
    logic       out_last_reg;

    assign load    = cmd_valid && (!out_valid_reg || out_ready);
    assign cmd_pop = load && cmd_done;

    // First step of a fresh item comes from its classification
    always_comb
    begin
        if (active_reg)
        begin
            cur_step = step_reg;
        end
        else if (cmd.pre_close)
        begin
            cur_step = STEP_PRE_STOP;
        end
        else if (cmd.open)
        begin
            cur_step = STEP_START;
        end
        else
        begin
            cur_step = STEP_DATA;
        end
    end

    // Next state
    always_comb
    begin
        succ_step = cur_step;
        cmd_done  = 1'b0;
        case (cur_step)
            STEP_PRE_STOP:  succ_step = STEP_PRE_POLL;
            STEP_PRE_POLL:  succ_step = STEP_START;
            STEP_START:     succ_step = STEP_DEV;
            STEP_DEV:       succ_step = STEP_ADDR;
            STEP_ADDR:      succ_step = STEP_DATA;
            STEP_DATA:
            begin
                succ_step = STEP_POST_STOP;
                cmd_done  = !cmd.post_close;
            end
            STEP_POST_STOP: succ_step = STEP_POST_POLL;
            STEP_POST_POLL: cmd_done  = 1'b1;
            default:        cmd_done  = 1'b1;
        endcase

        step_next   = step_reg;
        active_next = active_reg;
        if (load)
        begin
            step_next   = succ_step;
            active_next = !cmd_done;
        end
    end

    // Outputs of the current step
    always_comb
    begin
        act = ACT_SEND;
        val = 8'd0;
        case (cur_step)
            STEP_PRE_STOP:  act = ACT_STOP;
            STEP_PRE_POLL:  act = ACT_POLL;
            STEP_START:     act = ACT_START;
            STEP_DEV:       val = {device_address[7:1], 1'b0};
            STEP_ADDR:      val = cmd.seg_addr;
            STEP_DATA:      val = cmd.data;
            STEP_POST_STOP: act = ACT_STOP;
            STEP_POST_POLL: act = ACT_POLL;
            default:        act = ACT_STOP;
        endcase
    end

    assign out_valid_next = load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_PRE_STOP;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_value_reg  <= val;
            out_action_reg <= act;
            out_last_reg   <= cmd_done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_action = out_action_reg;
    assign out_last   = out_last_reg;

endmodule
`default_nettype wire

>>> design/epwf_checker.sv
`default_nettype none
`include "assert_macros.svh"
module epwf_checker
    import epwf_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser,
    input wire logic       m_tlast
);

    logic       seen_reg;
    logic [1:0] prev_act_reg;
    logic       out_take;

    assign out_take = m_tvalid && m_tready;

    // Track the last action taken by the receiver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            prev_act_reg <= ACT_POLL;
        end
        else if (out_take)
        begin
            seen_reg     <= 1'b1;
            prev_act_reg <= m_tuser;
        end
    end

    `EPWF_ASSERT(a_hold_stall, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output item changed while stalled")
    `EPWF_ASSERT_IMPL(a_start_after_poll, out_take && m_tuser == ACT_START, !seen_reg || prev_act_reg == ACT_POLL, "start not preceded by standby poll")
    `EPWF_ASSERT_IMPL(a_poll_after_stop, out_take && m_tuser == ACT_POLL, seen_reg && prev_act_reg == ACT_STOP, "standby poll not preceded by stop")
    `EPWF_ASSERT_IMPL(a_zero_value, m_tvalid && m_tuser != ACT_SEND, m_tdata == 8'd0, "nonzero value on a non-send action")
    `EPWF_ASSERT_IMPL(a_run_end_kind, m_tvalid && m_tlast, m_tuser == ACT_SEND || m_tuser == ACT_POLL, "run end on a start or stop action")

endmodule

bind eeprom_page_write_framer_top epwf_checker u_epwf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
